>>> src/assert_macros.svh
// Assertion macros used by the top level of the matrix engine.
// Needs clk and rst_n in the scope of each use; empty when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define MAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds
`define MAM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MAM_ASSERT(lbl, prop, msg)
`define MAM_NEVER(lbl, cond, msg)
`endif

`endif

>>> src/mam_pkg.sv
// Shared types, constants and helpers of the matrix add/sub/multiply engine.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps

package mam_pkg;

  localparam int DIM_DEF  = 8;   // default matrix bound
  localparam int IDX_W    = 3;   // row and column index width
  localparam int VAL_W    = 32;  // element width
  localparam int MODE_W   = 2;
  localparam int DREG_W   = 4;   // dimension register width
  localparam int CFG_IX_W = 2;
  localparam int TDATA_W  = 40;  // row, col, value padded to bytes

  // Register indexes of the configuration port
  localparam logic [CFG_IX_W-1:0] REG_MODE  = 2'd0;
  localparam logic [CFG_IX_W-1:0] REG_ROWS  = 2'd1;
  localparam logic [CFG_IX_W-1:0] REG_INNER = 2'd2;
  localparam logic [CFG_IX_W-1:0] REG_COLS  = 2'd3;

  // Operation codes (bit 1 alone selects the product)
  localparam int OP_MUL_BIT = 1;
  localparam int OP_SUB_BIT = 0;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DREG_W-1:0] rows;
    logic [DREG_W-1:0] inner;
    logic [DREG_W-1:0] cols;
  } cfg_t;

  typedef struct packed {
    logic             we;
    logic             sel;   // 0 A, 1 B
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } wr_req_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] a_row;
    logic [IDX_W-1:0] a_col;
    logic [IDX_W-1:0] b_row;
    logic [IDX_W-1:0] b_col;
  } rd_req_t;

  // Clamp a dimension register to 1..dmax and return its last index
  function automatic logic [IDX_W-1:0] last_index(input logic [DREG_W-1:0] v,
                                                  input logic [DREG_W-1:0] dmax);
    logic [DREG_W-1:0] c;
    c = v;
    if (v == '0) c = DREG_W'(1);
    else if (v > dmax) c = dmax;
    last_index = IDX_W'(c - DREG_W'(1));
  endfunction

endpackage

>>> src/mam_store.sv
// Element stores for matrices A and B: one write port, one registered read each.
// Depends on mam_pkg for the request structs.
`timescale 1ns / 1ps

module mam_store #(
  parameter int DIM = mam_pkg::DIM_DEF
) (
  input  logic                      clk,
  input  mam_pkg::wr_req_t          wr_req,
  input  mam_pkg::rd_req_t          rd_req,
  output logic [mam_pkg::VAL_W-1:0] rd_a,
  output logic [mam_pkg::VAL_W-1:0] rd_b
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [mam_pkg::VAL_W-1:0] mem_a [DEPTH];
  logic [mam_pkg::VAL_W-1:0] mem_b [DEPTH];

  logic [AW-1:0] wr_addr;
  logic [AW-1:0] ra_addr;
  logic [AW-1:0] rb_addr;
  logic          wr_in_range;

  // Linear address is row * DIM + col
  assign wr_addr = AW'(wr_req.row) * AW'(DIM) + AW'(wr_req.col);
  assign ra_addr = AW'(rd_req.a_row) * AW'(DIM) + AW'(rd_req.a_col);
  assign rb_addr = AW'(rd_req.b_row) * AW'(DIM) + AW'(rd_req.b_col);

  // Drop loads whose row or column lies outside the matrix bound
  assign wr_in_range = ({1'b0, wr_req.row} < (mam_pkg::IDX_W + 1)'(DIM)) &&
                       ({1'b0, wr_req.col} < (mam_pkg::IDX_W + 1)'(DIM));

  always_ff @(posedge clk) begin
    if (wr_req.we && wr_in_range && !wr_req.sel) begin
      mem_a[wr_addr] <= wr_req.value;
    end
    if (wr_req.we && wr_in_range && wr_req.sel) begin
      mem_b[wr_addr] <= wr_req.value;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_req.re) begin
      rd_a <= mem_a[ra_addr];
      rd_b <= mem_b[rb_addr];
    end
  end

endmodule

>>> src/mam_ctrl.sv
// Sequencer and arithmetic pipeline: walks result elements, reads the stores,
// multiplies or adds, accumulates and holds one result. Depends on mam_pkg.
`timescale 1ns / 1ps

module mam_ctrl #(
  parameter int DIM = mam_pkg::DIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mam_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  input  logic                      in_last,
  output logic                      in_ready,
  output mam_pkg::rd_req_t          rd_req,
  input  logic [mam_pkg::VAL_W-1:0] rd_a,
  input  logic [mam_pkg::VAL_W-1:0] rd_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mam_pkg::IDX_W-1:0] out_row,
  output logic [mam_pkg::IDX_W-1:0] out_col,
  output logic [mam_pkg::VAL_W-1:0] out_value,
  output logic                      out_end
);

  localparam int IW = mam_pkg::IDX_W;
  localparam int VW = mam_pkg::VAL_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic [mam_pkg::MODE_W-1:0] op_r, op_nxt;
  logic [IW-1:0] rl_r, rl_nxt, cl_r, cl_nxt, kl_r, kl_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  // Stage 1: read data arriving from the stores
  logic          v1_r, f1_r, l1_r, e1_r;
  logic [IW-1:0] r1_r, c1_r;
  // Stage 2: product or elementwise sum
  logic          v2_r, f2_r, l2_r, e2_r;
  logic [IW-1:0] r2_r, c2_r;
  logic [VW-1:0] p2_r, p2_nxt;
  // Stage 3: accumulator and result register
  logic [VW-1:0] acc_r, acc_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_end_r;
  logic [IW-1:0] out_row_r, out_col_r;
  logic [VW-1:0] out_value_r;

  logic adv, issue, start, mul;
  logic k_done, j_done, i_done;
  logic [mam_pkg::DREG_W-1:0] dmax;

  assign dmax  = mam_pkg::DREG_W'(DIM);
  assign mul   = op_r[mam_pkg::OP_MUL_BIT];
  // Whole pipeline moves only when the result slot is free or draining
  assign adv   = !out_valid_r || out_ready;
  assign issue = (state_r == ST_RUN) && adv;
  assign in_ready = (state_r == ST_IDLE);
  assign start    = in_valid && in_ready && in_last;

  assign k_done = (k_r == kl_r);
  assign j_done = (j_r == cl_r);
  assign i_done = (i_r == rl_r);

  // Read request for the current inner step
  always_comb begin
    rd_req.re    = issue;
    rd_req.a_row = i_r;
    rd_req.a_col = mul ? k_r : j_r;
    rd_req.b_row = mul ? k_r : i_r;
    rd_req.b_col = j_r;
  end

  // Latch dimensions on start, then advance k, j, i
  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    rl_nxt = rl_r;
    cl_nxt = cl_r;
    kl_nxt = kl_r;
    i_nxt  = i_r;
    j_nxt  = j_r;
    k_nxt  = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          op_nxt = cfg.mode;
          rl_nxt = mam_pkg::last_index(cfg.rows, dmax);
          if (cfg.mode[mam_pkg::OP_MUL_BIT]) begin
            cl_nxt = mam_pkg::last_index(cfg.cols, dmax);
            kl_nxt = mam_pkg::last_index(cfg.inner, dmax);
          end else begin
            cl_nxt = mam_pkg::last_index(cfg.inner, dmax);
            kl_nxt = '0;
          end
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (!k_done) begin
            k_nxt = k_r + IW'(1);
          end else begin
            k_nxt = '0;
            if (!j_done) begin
              j_nxt = j_r + IW'(1);
            end else begin
              j_nxt = '0;
              if (!i_done) i_nxt = i_r + IW'(1);
              else state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Product (low word) or elementwise add/subtract
  always_comb begin
    if (mul) p2_nxt = rd_a * rd_b;
    else if (op_r[mam_pkg::OP_SUB_BIT]) p2_nxt = rd_a - rd_b;
    else p2_nxt = rd_a + rd_b;
  end

  assign acc_nxt = f2_r ? p2_r : acc_r + p2_r;

  assign out_valid_nxt = (out_valid_r && !out_ready) || (adv && v2_r && l2_r);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        v1_r <= issue;
        v2_r <= v1_r;
      end
    end
  end

  // Sequencer payload and pipeline data
  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    rl_r <= rl_nxt;
    cl_r <= cl_nxt;
    kl_r <= kl_nxt;
    i_r  <= i_nxt;
    j_r  <= j_nxt;
    k_r  <= k_nxt;
    if (adv) begin
      f1_r <= (k_r == '0);
      l1_r <= k_done;
      e1_r <= k_done && j_done && i_done;
      r1_r <= i_r;
      c1_r <= j_r;
      f2_r <= f1_r;
      l2_r <= l1_r;
      e2_r <= e1_r;
      r2_r <= r1_r;
      c2_r <= c1_r;
      p2_r <= p2_nxt;
    end
    if (adv && v2_r) begin
      acc_r <= acc_nxt;
    end
    if (adv && v2_r && l2_r) begin
      out_row_r   <= r2_r;
      out_col_r   <= c2_r;
      out_value_r <= acc_nxt;
      out_end_r   <= e2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_end   = out_end_r;

endmodule

>>> src/matrix_add_sub_multiply_engine_top.sv
// Top level of the integer matrix add/subtract/multiply engine.
// Depends on mam_pkg, mam_store, mam_ctrl and assert_macros.svh.
//
//  channel  | direction | contents
//  in_*     | slave     | tdata row/col/value, tuser matrix select, tlast starts work
//  out_*    | master    | tdata row/col/value, tlast on final result element
//  cfg_*    | write     | mode, rows_of_a, inner_size, cols_of_b by index 0..3
//
// Loads are accepted while the engine is idle. After a last load, add and subtract give
// one result per cycle while the output is not stalled; multiply accumulates inner_size
// products per result in the single multiply-accumulate unit, which reads one A and one
// B word per cycle. Input is held off until all reads of a run are issued. A stalled
// output freezes the whole pipeline. Reset is synchronous.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix_add_sub_multiply_engine_top #(
  parameter int DIM = mam_pkg::DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mam_pkg::TDATA_W-1:0]    in_tdata,   // row[2:0] col[5:3] value[37:6]
  input  logic                           in_tuser,   // matrix_sel[0]
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mam_pkg::TDATA_W-1:0]    out_tdata,  // out_row[2:0] out_col[5:3] out_value[37:6]
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [mam_pkg::CFG_IX_W-1:0]   cfg_index,
  input  logic [mam_pkg::DREG_W-1:0]     cfg_wdata
);

  localparam int IW = mam_pkg::IDX_W;
  localparam int VW = mam_pkg::VAL_W;

  mam_pkg::cfg_t    cfg_r;
  mam_pkg::wr_req_t wr_req;
  mam_pkg::rd_req_t rd_req;
  logic [VW-1:0] rd_a, rd_b;
  logic [IW-1:0] res_row, res_col;
  logic [VW-1:0] res_value;
  logic          res_end;
  logic [IW:0]   chk_row;
  logic          last_xfer;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= '0;
      cfg_r.rows  <= mam_pkg::DREG_W'(8);
      cfg_r.inner <= mam_pkg::DREG_W'(8);
      cfg_r.cols  <= mam_pkg::DREG_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mam_pkg::REG_MODE:  cfg_r.mode  <= cfg_wdata[mam_pkg::MODE_W-1:0];
        mam_pkg::REG_ROWS:  cfg_r.rows  <= cfg_wdata;
        mam_pkg::REG_INNER: cfg_r.inner <= cfg_wdata;
        mam_pkg::REG_COLS:  cfg_r.cols  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Store every accepted load
  always_comb begin
    wr_req.we    = in_tvalid && in_tready;
    wr_req.sel   = in_tuser;
    wr_req.row   = in_tdata[IW-1:0];
    wr_req.col   = in_tdata[2*IW-1:IW];
    wr_req.value = in_tdata[2*IW+VW-1:2*IW];
  end

  mam_store #(.DIM(DIM)) u_store (
    .clk    (clk),
    .wr_req (wr_req),
    .rd_req (rd_req),
    .rd_a   (rd_a),
    .rd_b   (rd_b)
  );

  mam_ctrl #(.DIM(DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .in_ready  (in_tready),
    .rd_req    (rd_req),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_row   (res_row),
    .out_col   (res_col),
    .out_value (res_value),
    .out_end   (res_end)
  );

  assign out_tdata = {(mam_pkg::TDATA_W - 2*IW - VW)'(0), res_value, res_col, res_row};
  assign out_tlast = res_end;
  assign chk_row   = {1'b0, res_row};
  assign last_xfer = in_tvalid && in_tready && in_tlast;

  `MAM_ASSERT(a_last_holds_input, last_xfer |=> !in_tready, "input taken right after last load")
  `MAM_NEVER(a_row_in_bound, out_tvalid && (chk_row >= (IW + 1)'(DIM)), "result row beyond bound")
  `MAM_NEVER(a_read_write_excl, wr_req.we && rd_req.re, "store write overlaps run reads")

endmodule
